/* hdl/b64d_pkg.sv */
// Shared types, constants and the character map of the Base64URL decoder.
`default_nettype none
package b64d_pkg;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_USCORE  = 8'h5F;

    localparam logic [7:0] LOWER_OFFSET = 8'd26;
    localparam logic [7:0] DIGIT_OFFSET = 8'd52;
    localparam logic [5:0] VAL_DASH     = 6'd62;
    localparam logic [5:0] VAL_USCORE   = 6'd63;

    localparam int ACC_W  = 12;
    localparam int HELD_W = 3;

    // pending bit counts; they track message length mod 4 = 0, 3, 2, 1
    localparam logic [HELD_W-1:0] HELD_0 = 3'd0;
    localparam logic [HELD_W-1:0] HELD_2 = 3'd2;
    localparam logic [HELD_W-1:0] HELD_4 = 3'd4;
    localparam logic [HELD_W-1:0] HELD_6 = 3'd6;

    typedef struct packed {
        logic       bad;
        logic [5:0] value;
    } t_char_map;

    typedef struct packed {
        logic [ACC_W-1:0]  acc;
        logic [HELD_W-1:0] held;
        logic              bad;
    } t_dec_state;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
        logic       message_ok;
    } t_result;

    function automatic t_char_map map_char(input logic [7:0] ch);
        t_char_map m;
        m.bad   = 1'b0;
        m.value = '0;
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            m.value = 6'(ch - CH_UPPER_A);
        end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            m.value = 6'(ch - CH_LOWER_A + LOWER_OFFSET);
        end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
            m.value = 6'(ch - CH_DIGIT_0 + DIGIT_OFFSET);
        end else if (ch == CH_DASH) begin
            m.value = VAL_DASH;
        end else if (ch == CH_USCORE) begin
            m.value = VAL_USCORE;
        end else begin
            m.bad = 1'b1;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

/* hdl/base64url_stream_decoder.sv */
// Top level of the streaming unpadded Base64URL decoder.
// Takes one character per beat and returns one result beat per character, one
// character per clock sustained while the output is not stalled. The character is
// captured in an input register, mapped and shifted into the 12-bit bit
// accumulator by single-level logic, and the result lands in an output
// register. A result carries a byte when the character completed eight bits;
// on the character flagged last it also reports whether the message was valid
// (no invalid character, length mod 4 not 1), and the state clears for the next
// message. Invalid characters count as zero and set a sticky error.
`default_nettype none
module base64url_stream_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_is_last,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_data_byte,
    output logic            o_has_byte,
    output logic            o_end_of_message,
    output logic            o_message_ok
);

    logic                  r_in_valid;
    logic [7:0]            r_in_char;
    logic                  r_in_last;
    b64d_pkg::t_dec_state  r_state;
    logic                  r_out_valid;
    b64d_pkg::t_result     r_out;

    b64d_pkg::t_dec_state  n_state;
    b64d_pkg::t_result     n_out;
    logic                  w_out_free;
    logic                  w_proc;
    logic                  w_take;

    assign w_out_free = ~r_out_valid | ~i_stall;
    assign w_proc     = r_in_valid & w_out_free;
    assign o_stall    = r_in_valid & ~w_out_free;
    assign w_take     = i_valid & ~o_stall;

    b64d_step u_step (
        .i_char_code (r_in_char),
        .i_is_last   (r_in_last),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_result    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (w_out_free) begin
                r_in_valid  <= w_take;
                r_out_valid <= r_in_valid;
            end else if (!r_in_valid) begin
                r_in_valid <= w_take;
            end
            if (w_proc) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_char <= i_char_code;
            r_in_last <= i_is_last;
        end
        if (w_proc) begin
            r_out <= n_out;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_data_byte      = r_out.data_byte;
    assign o_has_byte       = r_out.has_byte;
    assign o_end_of_message = r_out.end_of_message;
    assign o_message_ok     = r_out.message_ok;

    // pending bit count is always even
    a_held_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.held[0])
        else $error("odd pending bit count");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_in_last) |=> (r_state.acc == '0 && r_state.held == '0 && !r_state.bad))
        else $error("state not cleared after last character");

    a_ok_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_end_of_message) |-> !o_message_ok)
        else $error("message_ok outside end of message");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_byte) |-> (o_data_byte == 8'd0))
        else $error("data byte nonzero without byte");

endmodule
`default_nettype wire

/* hdl/b64d_step.sv */
// Combinational decode of one character against the current decoder state.
`default_nettype none
module b64d_step (
    input  wire logic [7:0]          i_char_code,
    input  wire logic                i_is_last,
    input  wire b64d_pkg::t_dec_state i_state,
    output b64d_pkg::t_dec_state      o_state,
    output b64d_pkg::t_result         o_result
);

    b64d_pkg::t_char_map                 w_map;
    logic [b64d_pkg::ACC_W-1:0]          w_acc;
    logic [b64d_pkg::HELD_W-1:0]         w_held;
    logic                                w_bad;
    logic [7:0]                          w_byte;
    logic                                w_has;

    assign w_map = b64d_pkg::map_char(i_char_code);
    assign w_acc = {i_state.acc[5:0], w_map.value};
    assign w_bad = i_state.bad | w_map.bad;

    // oldest eight bits leave once eight or more are held
    always_comb begin
        w_byte = '0;
        w_has  = 1'b1;
        w_held = b64d_pkg::HELD_0;
        unique case (i_state.held)
            b64d_pkg::HELD_0: begin
                w_has  = 1'b0;
                w_held = b64d_pkg::HELD_6;
            end
            b64d_pkg::HELD_2: begin
                w_byte = w_acc[7:0];
                w_held = b64d_pkg::HELD_0;
            end
            b64d_pkg::HELD_4: begin
                w_byte = w_acc[9:2];
                w_held = b64d_pkg::HELD_2;
            end
            b64d_pkg::HELD_6: begin
                w_byte = w_acc[11:4];
                w_held = b64d_pkg::HELD_4;
            end
            default: begin
                w_has  = 1'b0;
                w_held = b64d_pkg::HELD_0;
            end
        endcase
    end

    always_comb begin
        o_result.data_byte      = w_byte;
        o_result.has_byte       = w_has;
        o_result.end_of_message = i_is_last;
        o_result.message_ok     = i_is_last & ~w_bad & (w_held != b64d_pkg::HELD_6);
        if (i_is_last) begin
            o_state = '0;
        end else begin
            o_state.acc  = w_acc;
            o_state.held = w_held;
            o_state.bad  = w_bad;
        end
    end

endmodule
`default_nettype wire
